FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the steering unit rtl
// no dependencies; taken in by `include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define AST_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold outside reset
`define AST_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: hw/rtl/lfpd_pkg.sv
// package for the line follower pd steering unit: widths, register indexes,
// shared types and the sensor-to-error lookup; no dependencies
package lfpd_pkg;

    localparam int SPEED_W   = 12;
    localparam int GAIN_W    = 10;
    localparam int SENSOR_N  = 5;
    localparam int ERR_W     = 8;
    localparam int CFG_W     = (SPEED_W > GAIN_W) ? SPEED_W : GAIN_W;
    localparam int CFG_IDX_W = 3;
    localparam int UNIT      = 60;

    // speeds scaled by 60 (sixtieths of a unit)
    localparam int V60_W  = SPEED_W + 6;
    localparam int TURN_W = 20;
    localparam int X_W    = ((V60_W > TURN_W) ? V60_W : TURN_W) + 2;

    // shared signed multiplier operand widths
    localparam int MA_W = V60_W + 1;
    localparam int MB_W = SPEED_W + 2;
    localparam int P_W  = MA_W + MB_W;

    // reciprocal of 60 for the final truncation
    localparam int RCP_SHIFT = V60_W;
    localparam int RCP_W     = V60_W - 5;
    localparam logic [RCP_W-1:0] RCP_MUL = RCP_W'((64'd1 << RCP_SHIFT) / UNIT);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P   = 3'd0,
        REG_GAIN_D   = 3'd1,
        REG_STRAIGHT = 3'd2,
        REG_FLOOR    = 3'd3,
        REG_SLOWDOWN = 3'd4,
        REG_CEILING  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_d;
        logic [SPEED_W-1:0] straight_speed;
        logic [SPEED_W-1:0] floor_speed;
        logic [GAIN_W-1:0]  slowdown_gain;
        logic [SPEED_W-1:0] ceiling_speed;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic mul_p;
        logic mul_d;
        logic mul_b;
        logic wheel;
        logic div_l;
        logic div_r;
        logic out_load;
    } t_dp_cmd;

    // mean of weights -2..2 over lit sensors, in sixtieths; 60 divides by
    // every possible count so the mean is exact
    function automatic logic signed [ERR_W-1:0] sensor_offset(logic [SENSOR_N-1:0] bits);
        int sum;
        int cnt;
        int e;
        sum = 0;
        cnt = 0;
        for (int i = 0; i < SENSOR_N; i++) begin
            if (bits[i]) begin
                sum = sum + (i - SENSOR_N / 2);
                cnt = cnt + 1;
            end
        end
        case (cnt)
            1:       e = sum * UNIT;
            2:       e = sum * (UNIT / 2);
            3:       e = sum * (UNIT / 3);
            4:       e = sum * (UNIT / 4);
            5:       e = sum * (UNIT / 5);
            default: e = 0;
        endcase
        return ERR_W'(e);
    endfunction

endpackage

FILE: hw/rtl/lfpd_cfg.sv
// configuration register file of the steering unit
// depends on lfpd_pkg
module lfpd_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lfpd_pkg::CFG_W-1:0]      i_cfg_data,
    output lfpd_pkg::t_cfg                  o_cfg
);

    lfpd_pkg::t_cfg r_cfg;
    lfpd_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                lfpd_pkg::REG_GAIN_P:   n_cfg.gain_p = i_cfg_data[lfpd_pkg::GAIN_W-1:0];
                lfpd_pkg::REG_GAIN_D:   n_cfg.gain_d = i_cfg_data[lfpd_pkg::GAIN_W-1:0];
                lfpd_pkg::REG_STRAIGHT: begin
                    n_cfg.straight_speed = i_cfg_data[lfpd_pkg::SPEED_W-1:0];
                end
                lfpd_pkg::REG_FLOOR:    n_cfg.floor_speed = i_cfg_data[lfpd_pkg::SPEED_W-1:0];
                lfpd_pkg::REG_SLOWDOWN: begin
                    n_cfg.slowdown_gain = i_cfg_data[lfpd_pkg::GAIN_W-1:0];
                end
                lfpd_pkg::REG_CEILING:  begin
                    n_cfg.ceiling_speed = i_cfg_data[lfpd_pkg::SPEED_W-1:0];
                end
                // writes past the last register are dropped
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p         <= lfpd_pkg::GAIN_W'(78);
            r_cfg.gain_d         <= lfpd_pkg::GAIN_W'(150);
            r_cfg.straight_speed <= lfpd_pkg::SPEED_W'(850);
            r_cfg.floor_speed    <= lfpd_pkg::SPEED_W'(420);
            r_cfg.slowdown_gain  <= lfpd_pkg::GAIN_W'(150);
            r_cfg.ceiling_speed  <= lfpd_pkg::SPEED_W'(960);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/lfpd_dp.sv
// datapath of the steering unit: error lookup, shared multiplier, pd sum,
// base speed, wheel clamps, divide by 60 and the result register
// depends on lfpd_pkg and assert_macros.svh
`include "assert_macros.svh"

module lfpd_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lfpd_pkg::t_cfg                       i_cfg,
    input  lfpd_pkg::t_dp_cmd                    i_cmd,
    input  logic [lfpd_pkg::SENSOR_N-1:0]        i_sensor_bits,
    output logic [lfpd_pkg::SPEED_W-1:0]         o_left_speed,
    output logic [lfpd_pkg::SPEED_W-1:0]         o_right_speed,
    output logic signed [lfpd_pkg::ERR_W-1:0]    o_error_sixtieths,
    output logic                                 o_stop_flag,
    output logic                                 o_line_lost
);

    localparam int SW  = lfpd_pkg::SPEED_W;
    localparam int VW  = lfpd_pkg::V60_W;
    localparam int XW  = lfpd_pkg::X_W;
    localparam int TW  = lfpd_pkg::TURN_W;
    localparam int EW  = lfpd_pkg::ERR_W;
    localparam int MAW = lfpd_pkg::MA_W;
    localparam int MBW = lfpd_pkg::MB_W;
    localparam int PW  = lfpd_pkg::P_W;
    localparam int RS  = lfpd_pkg::RCP_SHIFT;

    // v * 60 as two shifts
    function automatic logic [VW-1:0] times60(logic [SW-1:0] v);
        return (VW'(v) << 6) - (VW'(v) << 2);
    endfunction

    // quotient estimate is low by at most one
    function automatic logic [SW-1:0] fix_quot(logic [VW-1:0] v, logic [SW-1:0] q);
        logic [VW:0] rem;
        rem = (VW + 1)'(v) - (VW + 1)'(times60(q));
        return (rem >= (VW + 1)'(lfpd_pkg::UNIT)) ? q + SW'(1) : q;
    endfunction

    logic signed [EW-1:0] r_err;
    logic signed [EW-1:0] r_prev;
    logic                 r_stop;
    logic                 r_lost;
    logic signed [TW-1:0] r_turn;
    logic signed [XW-1:0] r_base;
    logic [VW-1:0]        r_vl;
    logic [VW-1:0]        r_vr;
    logic [SW-1:0]        r_ql;
    logic [SW-1:0]        r_qr;

    logic [SW-1:0]        r_out_left;
    logic [SW-1:0]        r_out_right;
    logic signed [EW-1:0] r_out_err;
    logic                 r_out_stop;
    logic                 r_out_lost;

    logic                 in_lost;
    logic                 in_stop;
    logic signed [EW:0]   err_diff;
    logic [EW-1:0]        err_mag;
    logic signed [MAW-1:0] mul_a;
    logic signed [MBW-1:0] mul_b;
    logic signed [PW-1:0]  mul_p;
    logic signed [XW-1:0]  mul_x;
    logic signed [XW-1:0]  straight60;
    logic signed [XW-1:0]  floor60;
    logic signed [XW-1:0]  ceil60;
    logic signed [XW-1:0]  base_raw;
    logic signed [XW-1:0]  wheel_l;
    logic signed [XW-1:0]  wheel_r;
    logic [VW-1:0]         clamp_l;
    logic [VW-1:0]         clamp_r;
    logic [SW-1:0]         quot;

    assign in_lost  = (i_sensor_bits == '0);
    assign in_stop  = (i_sensor_bits == '1);
    assign err_diff = (EW + 1)'(r_err) - (EW + 1)'(r_prev);
    assign err_mag  = r_err[EW-1] ? EW'(-r_err) : EW'(r_err);

    // operand select for the one shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (1'b1)
            i_cmd.mul_p: begin
                mul_a = MAW'($signed({1'b0, i_cfg.gain_p}));
                mul_b = MBW'(r_err);
            end
            i_cmd.mul_d: begin
                mul_a = MAW'($signed({1'b0, i_cfg.gain_d}));
                mul_b = MBW'(err_diff);
            end
            i_cmd.mul_b: begin
                mul_a = MAW'($signed({1'b0, i_cfg.slowdown_gain}));
                mul_b = MBW'($signed({1'b0, err_mag}));
            end
            i_cmd.div_l: begin
                mul_a = MAW'($signed({1'b0, r_vl}));
                mul_b = MBW'($signed({1'b0, lfpd_pkg::RCP_MUL}));
            end
            i_cmd.div_r: begin
                mul_a = MAW'($signed({1'b0, r_vr}));
                mul_b = MBW'($signed({1'b0, lfpd_pkg::RCP_MUL}));
            end
            default: ;
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);
    assign mul_x = mul_p[XW-1:0];
    assign quot  = mul_p[RS+SW-1:RS];

    assign straight60 = $signed(XW'(times60(i_cfg.straight_speed)));
    assign floor60    = $signed(XW'(times60(i_cfg.floor_speed)));
    assign ceil60     = $signed(XW'(times60(i_cfg.ceiling_speed)));
    assign base_raw   = straight60 - mul_x;

    assign wheel_l = r_base - XW'(r_turn);
    assign wheel_r = r_base + XW'(r_turn);

    always_comb begin
        if (wheel_l > ceil60) begin
            clamp_l = ceil60[VW-1:0];
        end else if (wheel_l < 0) begin
            clamp_l = '0;
        end else begin
            clamp_l = wheel_l[VW-1:0];
        end
        if (wheel_r > ceil60) begin
            clamp_r = ceil60[VW-1:0];
        end else if (wheel_r < 0) begin
            clamp_r = '0;
        end else begin
            clamp_r = wheel_r[VW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= '0;
            r_stop     <= 1'b0;
            r_lost     <= 1'b0;
            r_out_stop <= 1'b0;
            r_out_lost <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_err  <= in_lost ? r_prev : lfpd_pkg::sensor_offset(i_sensor_bits);
                r_stop <= in_stop;
                r_lost <= in_lost;
            end
            if (i_cmd.mul_p) begin
                r_turn <= mul_x[TW-1:0];
            end
            if (i_cmd.mul_d) begin
                r_turn <= r_turn + mul_x[TW-1:0];
                r_prev <= r_err;
            end
            if (i_cmd.mul_b) begin
                r_base <= (base_raw < floor60) ? floor60 : base_raw;
            end
            if (i_cmd.wheel) begin
                r_vl <= clamp_l;
                r_vr <= clamp_r;
            end
            if (i_cmd.div_l) begin
                r_ql <= quot;
            end
            if (i_cmd.div_r) begin
                r_qr <= quot;
                r_ql <= fix_quot(r_vl, r_ql);
            end
            if (i_cmd.out_load) begin
                r_out_left  <= r_stop ? '0 : r_ql;
                r_out_right <= r_stop ? '0 : fix_quot(r_vr, r_qr);
                r_out_err   <= r_err;
                r_out_stop  <= r_stop;
                r_out_lost  <= r_lost;
            end
        end
    end

    assign o_left_speed      = r_out_left;
    assign o_right_speed     = r_out_right;
    assign o_error_sixtieths = r_out_err;
    assign o_stop_flag       = r_out_stop;
    assign o_line_lost       = r_out_lost;

    `AST_PROP(a_stop_err_zero, i_clk, i_rst_n, r_stop |-> (r_err == '0), "stop with nonzero error")
    `AST_NEVER(a_stop_and_lost, i_clk, i_rst_n, r_stop && r_lost, "stop and lost together")
    `AST_PROP(a_stop_speeds, i_clk, i_rst_n, o_stop_flag |-> (o_left_speed == '0 && o_right_speed == '0), "stop result with speed")

endmodule

FILE: hw/rtl/lfpd_ctrl.sv
// sequencer of the steering unit: one-hot state machine that steps the
// datapath through its multiply passes and owns both handshakes
// depends on lfpd_pkg and assert_macros.svh
`include "assert_macros.svh"

module lfpd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output lfpd_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_P    = 8'b0000_0010,
        S_D    = 8'b0000_0100,
        S_B    = 8'b0000_1000,
        S_W    = 8'b0001_0000,
        S_QL   = 8'b0010_0000,
        S_QR   = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;
    logic   accept;

    assign out_free = !r_out_valid || i_out_ready;
    assign accept   = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_P;
                end
            end
            S_P: begin
                o_cmd.mul_p = 1'b1;
                n_state     = S_D;
            end
            S_D: begin
                o_cmd.mul_d = 1'b1;
                n_state     = S_B;
            end
            S_B: begin
                o_cmd.mul_b = 1'b1;
                n_state     = S_W;
            end
            S_W: begin
                o_cmd.wheel = 1'b1;
                n_state     = S_QL;
            end
            S_QL: begin
                o_cmd.div_l = 1'b1;
                n_state     = S_QR;
            end
            S_QR: begin
                o_cmd.div_r = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                // hold here until the result register frees up
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `AST_PROP(a_accept_starts, i_clk, i_rst_n, accept |=> (r_state == S_P), "request accepted but no start")
    `AST_PROP(a_out_wait, i_clk, i_rst_n, (r_state == S_OUT && !out_free) |=> (r_state == S_OUT), "result dropped while blocked")
    `AST_PROP(a_load_shows, i_clk, i_rst_n, o_cmd.out_load |=> o_out_valid, "loaded result not shown")

endmodule

FILE: hw/rtl/line_follow_pd_steering_unit.sv
// top level of the five-sensor pd steering unit
// depends on lfpd_pkg, lfpd_cfg, lfpd_ctrl and lfpd_dp
//
//  channel  handshake                 payload
//  in       i_in_valid / o_in_ready   i_sensor_bits
//  out      o_out_valid / i_out_ready o_left_speed o_right_speed o_error_sixtieths
//                                     o_stop_flag o_line_lost
//  cfg      i_cfg_we                  i_cfg_index i_cfg_data
//
// a request runs through accept, then seven steps of the sequencer, five of
// them passes through the single shared multiplier (p, d, slowdown, two divides)
// the result sits in an output register; a new request is taken while it waits
// a stalled output holds the sequencer in its last step until the register frees
// reset is synchronous, active low, and restores the register defaults and a
// zero previous error

module line_follow_pd_steering_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [lfpd_pkg::SENSOR_N-1:0]        i_sensor_bits,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [lfpd_pkg::SPEED_W-1:0]         o_left_speed,
    output logic [lfpd_pkg::SPEED_W-1:0]         o_right_speed,
    output logic signed [lfpd_pkg::ERR_W-1:0]    o_error_sixtieths,
    output logic                                 o_stop_flag,
    output logic                                 o_line_lost,
    input  logic                                 i_cfg_we,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lfpd_pkg::CFG_W-1:0]           i_cfg_data
);

    lfpd_pkg::t_cfg    cfg;
    lfpd_pkg::t_dp_cmd cmd;

    lfpd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lfpd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    lfpd_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_cmd             (cmd),
        .i_sensor_bits     (i_sensor_bits),
        .o_left_speed      (o_left_speed),
        .o_right_speed     (o_right_speed),
        .o_error_sixtieths (o_error_sixtieths),
        .o_stop_flag       (o_stop_flag),
        .o_line_lost       (o_line_lost)
    );

endmodule
